@@ hw/rtl/mf_pkg.sv @@
// shared types, codes and arithmetic helpers of the factorization block
package mf_pkg;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         user_index;
    logic [9:0]         item_index;
    logic signed [15:0] rating;
    logic [3:0]         factor_index;
    logic               load_side;
    logic signed [15:0] load_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] prediction;
    logic signed [15:0] error;
  } out_t;

  localparam logic [1:0] FUNC_TRAIN   = 2'd0;
  localparam logic [1:0] FUNC_PREDICT = 2'd1;
  localparam logic [1:0] FUNC_LOAD    = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  localparam logic [2:0] CFG_MEAN  = 3'd0;
  localparam logic [2:0] CFG_LR    = 3'd1;
  localparam logic [2:0] CFG_REG   = 3'd2;
  localparam logic [2:0] CFG_UCNT  = 3'd3;
  localparam logic [2:0] CFG_ICNT  = 3'd4;

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = 42;
  localparam int WIDE_W  = 48;

  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -48'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mf_ram.sv @@
// simple memory, one write port and one registered read port
module mf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mf_mul.sv @@
// shared signed multiplier with registered product
module mf_mul (
  input  logic                               clk_i,
  input  logic signed [mf_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [mf_pkg::MUL_B_W-1:0]  b_i,
  output logic signed [mf_pkg::MUL_P_W-1:0]  p_o
);

  logic signed [mf_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ hw/rtl/matrix_factorization_sgd.sv @@
// Biased matrix-factorization recommender trained by SGD, fixed point. After reset the
// bias tables are cleared one entry a cycle, while no item is taken. One item is in
// work at a time and all multiplication runs through one shared multiplier with a
// registered product. A predict skips the dot term when it is dropped; a train
// computes the dot product pipelined one factor a cycle, then updates the two biases
// and each factor of the user row and then of the item row. A finished result waits
// while the output is stalled.
module matrix_factorization_sgd #(
  parameter int MAX_USERS    = 1024,
  parameter int MAX_ITEMS    = 1024,
  parameter int FACTOR_COUNT = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mf_pkg::in_t   in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mf_pkg::out_t  out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int UIW   = $clog2(MAX_USERS);
  localparam int IIW   = $clog2(MAX_ITEMS);
  localparam int UFAW  = $clog2(MAX_USERS * FACTOR_COUNT);
  localparam int IFAW  = $clog2(MAX_ITEMS * FACTOR_COUNT);
  localparam int KW    = (FACTOR_COUNT > 1) ? $clog2(FACTOR_COUNT) : 1;
  localparam int CLR_N = (MAX_USERS > MAX_ITEMS) ? MAX_USERS : MAX_ITEMS;
  localparam int CW    = $clog2(CLR_N);
  localparam int ACC_W = 32 + $clog2(FACTOR_COUNT) + 1;
  localparam int AW    = mf_pkg::MUL_A_W;
  localparam int BW    = mf_pkg::MUL_B_W;
  localparam int PW    = mf_pkg::MUL_P_W;
  localparam int WW    = mf_pkg::WIDE_W;

  typedef enum logic [16:0] {
    ST_IDLE    = 17'h00001,
    ST_CLEAR   = 17'h00002,
    ST_BIAS_RD = 17'h00004,
    ST_DOT     = 17'h00008,
    ST_DOT_END = 17'h00010,
    ST_PRED    = 17'h00020,
    ST_ERR     = 17'h00040,
    ST_B_REG   = 17'h00080,
    ST_B_LR    = 17'h00100,
    ST_B_WR    = 17'h00200,
    ST_F_RD    = 17'h00400,
    ST_F_M1    = 17'h00800,
    ST_F_M2    = 17'h01000,
    ST_F_M3    = 17'h02000,
    ST_F_WR    = 17'h04000,
    ST_LOAD    = 17'h08000,
    ST_DONE    = 17'h10000
  } st_e;

  st_e st_q, st_d;
  logic [KW-1:0] k_q, k_d;
  logic [CW-1:0] clr_q, clr_d;
  logic bs_q, bs_d, fs_q, fs_d, pv_q, pv_d, ok_q, ok_d;
  logic out_valid_q, out_valid_d;

  mf_pkg::in_t  in_q;
  mf_pkg::out_t out_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [15:0] pred_q, pred_d, err_q, err_d;
  logic signed [AW-1:0] t_q, t_d;
  logic [UFAW-1:0] ubase_q;
  logic [IFAW-1:0] ibase_q;

  logic signed [15:0] mean_q;
  logic [15:0] lr_q, rg_q;
  logic [10:0] ucnt_q, icnt_q;

  logic accept;
  logic is_train, uok, iok, use_u, use_i, use_dot;
  logic k_last;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  logic ub_we, ub_re, ib_we, ib_re;
  logic [UIW-1:0] ub_waddr, ub_raddr;
  logic [IIW-1:0] ib_waddr, ib_raddr;
  logic [15:0] ub_wdata, ib_wdata, ub_rdata, ib_rdata;
  logic uf_we, uf_re, if_we, if_re;
  logic [UFAW-1:0] uf_waddr, uf_raddr;
  logic [IFAW-1:0] if_waddr, if_raddr;
  logic [15:0] uf_wdata, if_wdata, uf_rdata, if_rdata;

  logic signed [15:0] bias_cur, fac_cur, fac_oth, new_val;
  logic signed [WW-1:0] sum_w, p_sh16, p_sh8;

  assign accept     = in_valid_i && (st_q == ST_IDLE);
  assign in_stall_o = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign is_train = (in_q.func == mf_pkg::FUNC_TRAIN);
  assign uok = ({1'b0, in_q.user_index} < ucnt_q) && (32'(in_q.user_index) < MAX_USERS);
  assign iok = ({1'b0, in_q.item_index} < icnt_q) && (32'(in_q.item_index) < MAX_ITEMS);
  assign use_u   = is_train || uok;
  assign use_i   = is_train || iok;
  assign use_dot = is_train || (uok && iok);
  assign k_last  = (k_q == KW'(FACTOR_COUNT - 1));

  assign bias_cur = bs_q ? $signed(ib_rdata) : $signed(ub_rdata);
  assign fac_cur  = fs_q ? $signed(if_rdata) : $signed(uf_rdata);
  assign fac_oth  = fs_q ? $signed(uf_rdata) : $signed(if_rdata);
  assign p_sh16   = WW'(mul_p >>> 16);
  assign p_sh8    = WW'(mul_p >>> 8);

  mf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mf_ram #(.DEPTH(MAX_USERS), .WIDTH(16)) u_ubias (
    .clk_i(clk_i), .we_i(ub_we), .waddr_i(ub_waddr), .wdata_i(ub_wdata),
    .re_i(ub_re), .raddr_i(ub_raddr), .rdata_o(ub_rdata)
  );

  mf_ram #(.DEPTH(MAX_ITEMS), .WIDTH(16)) u_ibias (
    .clk_i(clk_i), .we_i(ib_we), .waddr_i(ib_waddr), .wdata_i(ib_wdata),
    .re_i(ib_re), .raddr_i(ib_raddr), .rdata_o(ib_rdata)
  );

  mf_ram #(.DEPTH(MAX_USERS * FACTOR_COUNT), .WIDTH(16)) u_ufac (
    .clk_i(clk_i), .we_i(uf_we), .waddr_i(uf_waddr), .wdata_i(uf_wdata),
    .re_i(uf_re), .raddr_i(uf_raddr), .rdata_o(uf_rdata)
  );

  mf_ram #(.DEPTH(MAX_ITEMS * FACTOR_COUNT), .WIDTH(16)) u_ifac (
    .clk_i(clk_i), .we_i(if_we), .waddr_i(if_waddr), .wdata_i(if_wdata),
    .re_i(if_re), .raddr_i(if_raddr), .rdata_o(if_rdata)
  );

  always_comb begin
    st_d   = st_q;
    k_d    = k_q;
    clr_d  = clr_q;
    bs_d   = bs_q;
    fs_d   = fs_q;
    pv_d   = 1'b0;
    ok_d   = ok_q;
    acc_d  = acc_q;
    pred_d = pred_q;
    err_d  = err_q;
    t_d    = t_q;
    out_valid_d = out_valid_q && out_stall_i;

    mul_a = '0;
    mul_b = '0;
    sum_w = '0;
    new_val = '0;

    ub_we = 1'b0; ub_re = 1'b0; ub_waddr = UIW'(in_q.user_index); ub_wdata = '0;
    ib_we = 1'b0; ib_re = 1'b0; ib_waddr = IIW'(in_q.item_index); ib_wdata = '0;
    ub_raddr = UIW'(in_q.user_index);
    ib_raddr = IIW'(in_q.item_index);
    uf_we = 1'b0; uf_re = 1'b0; uf_wdata = '0;
    if_we = 1'b0; if_re = 1'b0; if_wdata = '0;
    uf_raddr = ubase_q + UFAW'(k_q);
    if_raddr = ibase_q + IFAW'(k_q);
    uf_waddr = uf_raddr;
    if_waddr = if_raddr;

    case (st_q)
      ST_CLEAR: begin
        ub_we    = (32'(clr_q) < MAX_USERS);
        ib_we    = (32'(clr_q) < MAX_ITEMS);
        ub_waddr = UIW'(clr_q);
        ib_waddr = IIW'(clr_q);
        if (clr_q == CW'(CLR_N - 1)) begin
          st_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          acc_d  = '0;
          pred_d = '0;
          err_d  = '0;
          k_d    = '0;
          bs_d   = 1'b0;
          fs_d   = 1'b0;
          case (in_data_i.func)
            mf_pkg::FUNC_TRAIN: begin
              if ((32'(in_data_i.user_index) < MAX_USERS) &&
                  (32'(in_data_i.item_index) < MAX_ITEMS)) begin
                st_d = ST_BIAS_RD;
              end else begin
                st_d = ST_DONE;
              end
            end
            mf_pkg::FUNC_PREDICT: st_d = ST_BIAS_RD;
            mf_pkg::FUNC_LOAD: begin
              ok_d = (32'(in_data_i.factor_index) < FACTOR_COUNT) &&
                     (in_data_i.load_side ? (32'(in_data_i.item_index) < MAX_ITEMS)
                                          : (32'(in_data_i.user_index) < MAX_USERS));
              st_d = ST_LOAD;
            end
            default: st_d = ST_DONE;
          endcase
        end
      end
      ST_BIAS_RD: begin
        ub_re = 1'b1;
        ib_re = 1'b1;
        uf_re = 1'b1;
        if_re = 1'b1;
        st_d  = use_dot ? ST_DOT : ST_PRED;
      end
      ST_DOT: begin
        // read of the next factor overlaps the multiply of this one
        mul_a = AW'($signed(uf_rdata));
        mul_b = BW'($signed(if_rdata));
        pv_d  = 1'b1;
        if (pv_q) begin
          acc_d = acc_q + ACC_W'(mul_p);
        end
        if (k_last) begin
          st_d = ST_DOT_END;
        end else begin
          k_d   = k_q + 1'b1;
          uf_re = 1'b1;
          if_re = 1'b1;
          uf_raddr = ubase_q + UFAW'(k_q + 1'b1);
          if_raddr = ibase_q + IFAW'(k_q + 1'b1);
        end
      end
      ST_DOT_END: begin
        acc_d = acc_q + ACC_W'(mul_p);
        st_d  = ST_PRED;
      end
      ST_PRED: begin
        sum_w = WW'(mean_q);
        if (use_u) begin
          sum_w = sum_w + WW'($signed(ub_rdata));
        end
        if (use_i) begin
          sum_w = sum_w + WW'($signed(ib_rdata));
        end
        if (use_dot) begin
          sum_w = sum_w + WW'(acc_q >>> 16);
        end
        pred_d = mf_pkg::sat16(sum_w);
        st_d   = is_train ? ST_ERR : ST_DONE;
      end
      ST_ERR: begin
        err_d = mf_pkg::sat16(WW'(in_q.rating) - WW'(pred_q));
        st_d  = ST_B_REG;
      end
      ST_B_REG: begin
        mul_a = AW'(bias_cur);
        mul_b = BW'({1'b0, rg_q});
        st_d  = ST_B_LR;
      end
      ST_B_LR: begin
        mul_a = AW'(WW'(err_q) - p_sh16);
        mul_b = BW'({1'b0, lr_q});
        st_d  = ST_B_WR;
      end
      ST_B_WR: begin
        new_val = mf_pkg::sat16(WW'(bias_cur) + p_sh16);
        ub_wdata = new_val;
        ib_wdata = new_val;
        if (bs_q) begin
          ib_we = 1'b1;
          k_d   = '0;
          st_d  = ST_F_RD;
        end else begin
          ub_we = 1'b1;
          bs_d  = 1'b1;
          st_d  = ST_B_REG;
        end
      end
      ST_F_RD: begin
        uf_re = 1'b1;
        if_re = 1'b1;
        st_d  = ST_F_M1;
      end
      ST_F_M1: begin
        mul_a = AW'(err_q);
        mul_b = BW'(fac_oth);
        st_d  = ST_F_M2;
      end
      ST_F_M2: begin
        t_d   = AW'(p_sh8);
        mul_a = AW'(fac_cur);
        mul_b = BW'({1'b0, rg_q});
        st_d  = ST_F_M3;
      end
      ST_F_M3: begin
        mul_a = AW'(WW'(t_q) - p_sh16);
        mul_b = BW'({1'b0, lr_q});
        st_d  = ST_F_WR;
      end
      ST_F_WR: begin
        new_val  = mf_pkg::sat16(WW'(fac_cur) + p_sh16);
        uf_wdata = new_val;
        if_wdata = new_val;
        uf_we    = !fs_q;
        if_we    = fs_q;
        if (k_last) begin
          k_d = '0;
          if (fs_q) begin
            st_d = ST_DONE;
          end else begin
            fs_d = 1'b1;
            st_d = ST_F_RD;
          end
        end else begin
          k_d  = k_q + 1'b1;
          st_d = ST_F_RD;
        end
      end
      ST_LOAD: begin
        uf_waddr = ubase_q + UFAW'(in_q.factor_index);
        if_waddr = ibase_q + IFAW'(in_q.factor_index);
        uf_wdata = in_q.load_value;
        if_wdata = in_q.load_value;
        uf_we    = ok_q && !in_q.load_side;
        if_we    = ok_q && in_q.load_side;
        st_d     = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLEAR;
      k_q         <= '0;
      clr_q       <= '0;
      bs_q        <= 1'b0;
      fs_q        <= 1'b0;
      pv_q        <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      mean_q      <= '0;
      lr_q        <= 16'd655;
      rg_q        <= 16'd1311;
      ucnt_q      <= 11'd1024;
      icnt_q      <= 11'd1024;
    end else begin
      st_q        <= st_d;
      k_q         <= k_d;
      clr_q       <= clr_d;
      bs_q        <= bs_d;
      fs_q        <= fs_d;
      pv_q        <= pv_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          mf_pkg::CFG_MEAN: mean_q <= $signed(cfg_data_i);
          mf_pkg::CFG_LR:   lr_q   <= cfg_data_i;
          mf_pkg::CFG_REG:  rg_q   <= cfg_data_i;
          mf_pkg::CFG_UCNT: ucnt_q <= cfg_data_i[10:0];
          mf_pkg::CFG_ICNT: icnt_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    pred_q <= pred_d;
    err_q  <= err_d;
    t_q    <= t_d;
    if (accept) begin
      in_q    <= in_data_i;
      ubase_q <= UFAW'(in_data_i.user_index) * UFAW'(FACTOR_COUNT);
      ibase_q <= IFAW'(in_data_i.item_index) * IFAW'(FACTOR_COUNT);
    end
    if ((st_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_q.prediction <= pred_q;
      out_q.error      <= err_q;
    end
  end

endmodule

@@ dv/testbench.sv @@
// self-checking testbench of the biased matrix-factorization sgd block
module testbench;

  localparam int NUSER = 1024;
  localparam int NITEM = 1024;
  localparam int NFAC = 16;
  localparam int WATCHDOG = 400000;
  localparam int IN_W = $bits(mf_pkg::in_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mf_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mf_pkg::out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  matrix_factorization_sgd uut (.*);

  initial forever #5 clk_i = ~clk_i;

  // predictor state
  longint mean_q, lr_q, reg_q, ucnt_q, icnt_q;
  shortint ubias[NUSER];
  shortint ibias[NITEM];
  shortint ufac[NUSER*NFAC];
  shortint ifac[NITEM*NFAC];
  bit uloaded[NUSER];
  bit iloaded[NITEM];
  int ready_users[$];
  int ready_items[$];

  mf_pkg::out_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  function automatic longint fl(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint row_dot(int u, int i);
    longint acc;
    acc = 0;
    for (int k = 0; k < NFAC; k++) acc += longint'(ufac[u*NFAC+k]) * longint'(ifac[i*NFAC+k]);
    return fl(acc, 16);
  endfunction

  function automatic shortint bias_update(longint b, longint e);
    longint d;
    d = e - fl(reg_q * b, 16);
    return shortint'(clip16(b + fl(lr_q * d, 16)));
  endfunction

  function automatic shortint factor_update(longint f, longint o, longint e);
    longint d;
    d = fl(e * o, 8) - fl(reg_q * f, 16);
    return shortint'(clip16(f + fl(lr_q * d, 16)));
  endfunction

  function automatic mf_pkg::out_t predict_sgd(mf_pkg::in_t x);
    mf_pkg::out_t r;
    longint p, e, acc;
    int u, i;
    bit uok, iok;
    u = x.user_index;
    i = x.item_index;
    p = 0;
    e = 0;
    if (x.func == mf_pkg::FUNC_TRAIN) begin
      p = clip16(mean_q + ubias[u] + ibias[i] + row_dot(u, i));
      e = clip16(longint'(x.rating) - p);
      ubias[u] = bias_update(ubias[u], e);
      ibias[i] = bias_update(ibias[i], e);
      for (int k = 0; k < NFAC; k++)
        ufac[u*NFAC+k] = factor_update(ufac[u*NFAC+k], ifac[i*NFAC+k], e);
      for (int k = 0; k < NFAC; k++)
        ifac[i*NFAC+k] = factor_update(ifac[i*NFAC+k], ufac[u*NFAC+k], e);
    end else if (x.func == mf_pkg::FUNC_PREDICT) begin
      uok = u < ucnt_q;
      iok = i < icnt_q;
      acc = mean_q;
      if (uok) acc += ubias[u];
      if (iok) acc += ibias[i];
      if (uok && iok) acc += row_dot(u, i);
      p = clip16(acc);
    end else if (x.func == mf_pkg::FUNC_LOAD) begin
      if (x.load_side == 1'b0) ufac[u*NFAC+x.factor_index] = x.load_value;
      else ifac[i*NFAC+x.factor_index] = x.load_value;
    end
    r.prediction = p[15:0];
    r.error = e[15:0];
    return r;
  endfunction

  // input driver
  task automatic send_item(mf_pkg::in_t x);
    @(negedge clk_i);
    in_data_i <= x;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_sgd(x));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 95) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 60);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (220) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mf_pkg::CFG_MEAN: mean_q = longint'($signed(val));
      mf_pkg::CFG_LR:   lr_q = longint'(val);
      mf_pkg::CFG_REG:  reg_q = longint'(val);
      mf_pkg::CFG_UCNT: ucnt_q = longint'(val[10:0]);
      mf_pkg::CFG_ICNT: icnt_q = longint'(val[10:0]);
      default: ;
    endcase
  endtask

  task automatic load_row(bit side, int idx, bit extreme);
    mf_pkg::in_t x;
    for (int k = 0; k < NFAC; k++) begin
      x = '0;
      x.func = mf_pkg::FUNC_LOAD;
      x.load_side = side;
      x.factor_index = 4'(k);
      x.user_index = side ? 10'($urandom) : 10'(idx);
      x.item_index = side ? 10'(idx) : 10'($urandom);
      x.rating = 16'($urandom);
      if (extreme) x.load_value = (k % 2) ? 16'sh8000 : 16'sh7fff;
      else x.load_value = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      send_item(x);
      sender_gap();
    end
    if (side) begin
      if (!iloaded[idx]) ready_items.push_back(idx);
      iloaded[idx] = 1'b1;
    end else begin
      if (!uloaded[idx]) ready_users.push_back(idx);
      uloaded[idx] = 1'b1;
    end
  endtask

  function automatic mf_pkg::in_t rand_use(bit narrow);
    mf_pkg::in_t x;
    x = mf_pkg::in_t'(IN_W'({$urandom, $urandom}));
    x.func = ($urandom_range(0, 2) == 0) ? mf_pkg::FUNC_PREDICT : mf_pkg::FUNC_TRAIN;
    x.user_index = 10'(ready_users[$urandom_range(0, ready_users.size()-1)]);
    x.item_index = 10'(ready_items[$urandom_range(0, ready_items.size()-1)]);
    if (narrow) x.rating = $signed(16'($urandom_range(0, 2047))) - 16'sd512;
    return x;
  endfunction

  task automatic test_directed();
    mf_pkg::in_t x;
    load_row(1'b0, 0, 1'b0);
    load_row(1'b1, 0, 1'b0);
    load_row(1'b0, 1023, 1'b1);
    load_row(1'b1, 1023, 1'b1);
    x = '0; x.func = mf_pkg::FUNC_PREDICT; send_item(x);
    x.func = mf_pkg::FUNC_TRAIN; x.rating = 16'sh7fff; send_item(x);
    x.rating = 16'sh8000; send_item(x);
    x.user_index = 1023; x.item_index = 1023; x.rating = 16'sh7fff; send_item(x);
    x.func = mf_pkg::FUNC_PREDICT; send_item(x);
    x.user_index = 0; send_item(x);
    x.func = mf_pkg::FUNC_UNUSED; x.load_value = 16'sh7fff; send_item(x);
    wait_drained();
    // count registers at their extremes: terms dropped out of range
    write_reg(mf_pkg::CFG_UCNT, 16'd1);
    write_reg(mf_pkg::CFG_ICNT, 16'd1);
    write_reg(mf_pkg::CFG_MEAN, 16'h7fff);
    x = '0; x.func = mf_pkg::FUNC_PREDICT; x.user_index = 1023; x.item_index = 0;
    send_item(x);
    x.user_index = 0; x.item_index = 1023; send_item(x);
    x.user_index = 0; x.item_index = 0; send_item(x);
    x.user_index = 1023; x.item_index = 1023; send_item(x);
    wait_drained();
    write_reg(mf_pkg::CFG_MEAN, 16'h8000);
    write_reg(mf_pkg::CFG_LR, 16'hffff);
    write_reg(mf_pkg::CFG_REG, 16'hffff);
    x = '0; x.func = mf_pkg::FUNC_TRAIN; x.rating = 16'sh8000; send_item(x);
    x.func = mf_pkg::FUNC_PREDICT; send_item(x);
    wait_drained();
    write_reg(mf_pkg::CFG_LR, 16'd0);
    write_reg(mf_pkg::CFG_REG, 16'd0);
    write_reg(mf_pkg::CFG_UCNT, 16'd1024);
    write_reg(mf_pkg::CFG_ICNT, 16'd1024);
    x = '0; x.func = mf_pkg::FUNC_TRAIN; x.user_index = 1023; x.rating = 16'sh1234;
    send_item(x);
    wait_drained();
  endtask

  task automatic test_random_phase(int n, bit narrow);
    mf_pkg::in_t x;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 19) == 0) begin
        load_row(1'($urandom_range(0, 1)), $urandom_range(0, 1023), 1'b0);
      end else begin
        x = rand_use(narrow);
        if ($urandom_range(0, 29) == 0) x.func = mf_pkg::FUNC_UNUSED;
        send_item(x);
      end
      sender_gap();
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    mf_pkg::in_t x;
    hold_off = 1'b1;
    for (int j = 0; j < 6; j++) begin
      x = rand_use(1'b1);
      send_item(x);
    end
    wait_drained();
  endtask

  task automatic test_settings();
    write_reg(mf_pkg::CFG_MEAN, 16'h0380);
    write_reg(mf_pkg::CFG_LR, 16'd655);
    write_reg(mf_pkg::CFG_REG, 16'd1311);
    test_random_phase(150, 1'b1);
    test_back_pressure();
    write_reg(mf_pkg::CFG_MEAN, 16'($urandom));
    write_reg(mf_pkg::CFG_LR, 16'($urandom));
    write_reg(mf_pkg::CFG_REG, 16'($urandom));
    write_reg(mf_pkg::CFG_UCNT, 16'($urandom_range(1, 1024)));
    write_reg(mf_pkg::CFG_ICNT, 16'($urandom_range(1, 1024)));
    test_random_phase(130, 1'b0);
    write_reg(mf_pkg::CFG_LR, 16'hffff);
    write_reg(mf_pkg::CFG_REG, 16'd0);
    write_reg(mf_pkg::CFG_UCNT, 16'd512);
    write_reg(mf_pkg::CFG_ICNT, 16'd1024);
    test_random_phase(110, 1'b0);
    write_reg(mf_pkg::CFG_MEAN, 16'd0);
    write_reg(mf_pkg::CFG_LR, 16'd2000);
    write_reg(mf_pkg::CFG_REG, 16'd4000);
    write_reg(mf_pkg::CFG_UCNT, 16'd1024);
    test_random_phase(140, 1'b1);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    mf_pkg::out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data_o);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.prediction !== want.prediction || out_data_o.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: prediction exp %0d got %0d, error exp %0d got %0d",
                     want.prediction, out_data_o.prediction, want.error, out_data_o.error);
        end
      end
    end
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
    else if (rst_ni) idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (1500) @(negedge clk_i);
        hold_off = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 60) out_stall_i <= 1'b0;
        else begin
          out_stall_i <= 1'b1;
          n = (n < 96) ? $urandom_range(1, 4) : $urandom_range(10, 80);
          repeat (n - 1) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    mean_q = 0; lr_q = 655; reg_q = 1311; ucnt_q = 1024; icnt_q = 1024;
    foreach (ubias[j]) ubias[j] = 0;
    foreach (ibias[j]) ibias[j] = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    for (int j = 0; j < 6; j++) begin
      load_row(1'b0, $urandom_range(1, 1022), 1'b0);
      load_row(1'b1, $urandom_range(1, 1022), 1'b0);
    end
    wait_drained();
    test_settings();
    if (mismatches == 0 && pending_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/mf_pkg.sv
hw/rtl/mf_ram.sv
hw/rtl/mf_mul.sv
hw/rtl/matrix_factorization_sgd.sv
dv/testbench.sv
